// ===== hdl/psos_pkg.sv =====
// ----------------------------------------------------------------------------
// psos_pkg
// Shared types and constants of the per-stock order statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package psos_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int USED_W        = IDX_W + 1;
  localparam int PAYLOAD_BITS  = 49;
  localparam int POS_W         = $clog2(PAYLOAD_BITS + 1);
  localparam int PKT_BITS      = 64;
  localparam int BIT_W         = $clog2(PKT_BITS + 1);
  localparam int STUFF_RUN     = 5;
  localparam int RUN_W         = $clog2(STUFF_RUN + 1);
  localparam int ID_W          = 32;
  localparam int SUM_W         = 40;
  localparam int CNT_W         = 32;

  // Destuffed payload handed from the front part to the back part.
  typedef logic [PAYLOAD_BITS-1:0] payload_t;

  // Statistics kept for one stock.
  typedef struct packed {
    logic [7:0]       min_sell;
    logic             has_sell;
    logic [7:0]       max_buy;
    logic             has_buy;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } stat_t;

  localparam int STAT_W = $bits(stat_t);

endpackage

`default_nettype wire

// ===== hdl/psos_ram.sv =====
// ----------------------------------------------------------------------------
// psos_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/psos_front.sv =====
// ----------------------------------------------------------------------------
// psos_front
// Accepts raw packets and removes the stuffed bits, one input bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psos_front
  import psos_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [PKT_BITS-1:0] in_raw_packet,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output payload_t                 push_data
);

  logic [PKT_BITS-1:0] pkt_r, pkt_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [RUN_W-1:0]    ones_r, ones_nxt;
  logic                skip_r, skip_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  payload_t            res_r, res_nxt;

  assign in_ready   = !busy_r && !done_r;
  assign push_valid = done_r;
  assign push_data  = res_r;

  // Destuffing walk: a run of five ones drops the following input bit.
  always_comb begin
    pkt_nxt  = pkt_r;
    bit_nxt  = bit_r;
    pos_nxt  = pos_r;
    ones_nxt = ones_r;
    skip_nxt = skip_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    res_nxt  = res_r;
    if (in_valid && in_ready) begin
      pkt_nxt  = in_raw_packet;
      bit_nxt  = '0;
      pos_nxt  = '0;
      ones_nxt = '0;
      skip_nxt = 1'b0;
      res_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (bit_r == BIT_W'(PKT_BITS) || pos_r == POS_W'(PAYLOAD_BITS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (skip_r) begin
          skip_nxt = 1'b0;
        end else if (pkt_r[bit_r[BIT_W-2:0]]) begin
          res_nxt[pos_r] = 1'b1;
          pos_nxt        = pos_r + POS_W'(1);
          if (ones_r == RUN_W'(STUFF_RUN - 1)) begin
            ones_nxt = '0;
            skip_nxt = 1'b1;
          end else begin
            ones_nxt = ones_r + RUN_W'(1);
          end
        end else begin
          ones_nxt = '0;
          pos_nxt  = pos_r + POS_W'(1);
        end
        bit_nxt = bit_r + BIT_W'(1);
      end
    end else if (done_r && push_ready) begin
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    pkt_r  <= pkt_nxt;
    bit_r  <= bit_nxt;
    pos_r  <= pos_nxt;
    ones_r <= ones_nxt;
    skip_r <= skip_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/psos_queue.sv =====
// ----------------------------------------------------------------------------
// psos_queue
// Two-entry queue of destuffed payloads between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module psos_queue
  import psos_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire payload_t push_data,
  output logic          pop_valid,
  input  wire logic     pop_ready,
  output payload_t      pop_data
);

  payload_t   mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill bookkeeping.
  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/psos_back.sv =====
// ----------------------------------------------------------------------------
// psos_back
// Looks the stock up in the key table, updates its statistics, and holds the
// result item.
// ----------------------------------------------------------------------------
`default_nettype none

module psos_back
  import psos_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire payload_t         pop_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [ID_W-1:0]       out_stock_id,
  output logic                  out_is_sell,
  output logic [7:0]            out_quantity,
  output logic [7:0]            out_order_value,
  output logic [7:0]            out_min_sell,
  output logic                  out_has_sell,
  output logic [7:0]            out_max_buy,
  output logic                  out_has_buy,
  output logic [SUM_W-1:0]      out_value_sum,
  output logic [CNT_W-1:0]      out_order_count,
  output logic                  out_dropped
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_KRD  = 7'b0000010,
    S_KCMP = 7'b0000100,
    S_MISS = 7'b0001000,
    S_DRD  = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              fresh_r, fresh_nxt;
  payload_t          pay_r, pay_nxt;
  stat_t             res_r, res_nxt;
  logic              drop_r, drop_nxt;

  logic [ID_W-1:0]   id;
  logic              sell;
  logic [7:0]        val;
  logic              key_we;
  logic [ID_W-1:0]   key_rdata;
  logic              stat_we;
  stat_t             stat_rdata;
  stat_t             base, upd;
  logic [SUM_W:0]    sum_wide;

  assign id   = pay_r[ID_W-1:0];
  assign sell = pay_r[ID_W];
  assign val  = pay_r[PAYLOAD_BITS-1:PAYLOAD_BITS-8];

  psos_ram #(.WIDTH(ID_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (idx_nxt),
    .wdata (id),
    .raddr (idx_r),
    .rdata (key_rdata)
  );

  psos_ram #(.WIDTH(STAT_W), .DEPTH(TABLE_ENTRIES)) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (idx_r),
    .wdata (upd),
    .raddr (idx_r),
    .rdata (stat_rdata)
  );

  // New statistics: a new entry starts from all zero.
  always_comb begin
    base     = fresh_r ? '0 : stat_rdata;
    upd      = base;
    if (sell) begin
      if (!base.has_sell || val < base.min_sell) begin
        upd.min_sell = val;
      end
      upd.has_sell = 1'b1;
    end else begin
      if (!base.has_buy || val > base.max_buy) begin
        upd.max_buy = val;
      end
      upd.has_buy = 1'b1;
    end
    sum_wide = {1'b0, base.sum} + (SUM_W + 1)'(val);
    upd.sum  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    if (base.count != '1) begin
      upd.count = base.count + CNT_W'(1);
    end
  end

  // Sequencer: linear key scan over the allocated entries, then read-modify-write.
  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    idx_nxt   = idx_r;
    fresh_nxt = fresh_r;
    pay_nxt   = pay_r;
    res_nxt   = res_r;
    drop_nxt  = drop_r;
    pop_ready = 1'b0;
    key_we    = 1'b0;
    stat_we   = 1'b0;
    case (state_r)
      S_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          pay_nxt   = pop_data;
          idx_nxt   = '0;
          fresh_nxt = 1'b0;
          state_nxt = (used_r == '0) ? S_MISS : S_KRD;
        end
      end
      S_KRD: begin
        state_nxt = S_KCMP;
      end
      S_KCMP: begin
        if (key_rdata == id) begin
          state_nxt = S_DRD;
        end else if (USED_W'(idx_r) + USED_W'(1) == used_r) begin
          state_nxt = S_MISS;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_KRD;
        end
      end
      S_MISS: begin
        if (used_r == USED_W'(TABLE_ENTRIES)) begin
          res_nxt   = '0;
          drop_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          idx_nxt   = used_r[IDX_W-1:0];
          key_we    = 1'b1;
          used_nxt  = used_r + USED_W'(1);
          fresh_nxt = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_DRD: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        stat_we   = 1'b1;
        res_nxt   = upd;
        drop_nxt  = 1'b0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
    end
    idx_r   <= idx_nxt;
    fresh_r <= fresh_nxt;
    pay_r   <= pay_nxt;
    res_r   <= res_nxt;
    drop_r  <= drop_nxt;
  end

  // Result item.
  assign out_valid       = state_r == S_OUT;
  assign out_stock_id    = id;
  assign out_is_sell     = sell;
  assign out_quantity    = pay_r[ID_W+8:ID_W+1];
  assign out_order_value = val;
  assign out_min_sell    = res_r.min_sell;
  assign out_has_sell    = res_r.has_sell;
  assign out_max_buy     = res_r.max_buy;
  assign out_has_buy     = res_r.has_buy;
  assign out_value_sum   = res_r.sum;
  assign out_order_count = res_r.count;
  assign out_dropped     = drop_r;

endmodule

`default_nettype wire

// ===== hdl/per_stock_order_statistics_unit.sv =====
// ----------------------------------------------------------------------------
// per_stock_order_statistics_unit
// Destuffs order packets and keeps per-stock order statistics.
// ----------------------------------------------------------------------------
// An item is walked through the destuffer one input bit a cycle and then
// through the lookup unit, which reads and compares each allocated table
// entry in turn; the two parts overlap through a two-entry queue. The key
// table is a single-port-read RAM searched linearly in allocation order;
// that scan sets the rate. No clearing pass is needed after reset.
`default_nettype none

module per_stock_order_statistics_unit
  import psos_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [PKT_BITS-1:0] in_raw_packet,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [ID_W-1:0]          out_stock_id,
  output logic                     out_is_sell,
  output logic [7:0]               out_quantity,
  output logic [7:0]               out_order_value,
  output logic [7:0]               out_min_sell,
  output logic                     out_has_sell,
  output logic [7:0]               out_max_buy,
  output logic                     out_has_buy,
  output logic [SUM_W-1:0]         out_value_sum,
  output logic [CNT_W-1:0]         out_order_count,
  output logic                     out_dropped
);

  logic     push_valid, push_ready, pop_valid, pop_ready;
  payload_t push_data, pop_data;

  psos_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_raw_packet (in_raw_packet),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  psos_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  psos_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_stock_id    (out_stock_id),
    .out_is_sell     (out_is_sell),
    .out_quantity    (out_quantity),
    .out_order_value (out_order_value),
    .out_min_sell    (out_min_sell),
    .out_has_sell    (out_has_sell),
    .out_max_buy     (out_max_buy),
    .out_has_buy     (out_has_buy),
    .out_value_sum   (out_value_sum),
    .out_order_count (out_order_count),
    .out_dropped     (out_dropped)
  );

endmodule

`default_nettype wire

// ===== hdl/psos_checker.sv =====
// ----------------------------------------------------------------------------
// psos_checker
// Port-level checks of the per-stock order statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

module psos_checker
  import psos_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [7:0]       out_min_sell,
  input wire logic             out_has_sell,
  input wire logic             out_has_buy,
  input wire logic [SUM_W-1:0] out_value_sum,
  input wire logic [CNT_W-1:0] out_order_count,
  input wire logic             out_dropped
);

  // A stalled result item holds its statistics.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_order_count)
      && $stable(out_value_sum) && $stable(out_dropped))
    else $error("result item changed while stalled");

  // A dropped order carries no statistics.
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_order_count == '0 && out_value_sum == '0
      && !out_has_sell && !out_has_buy)
    else $error("dropped item has statistics");

  // A recorded order has been counted and seen on one side at least.
  a_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dropped |-> out_order_count != '0
      && (out_has_sell || out_has_buy))
    else $error("recorded item without count");

  // The minimum sell value is zero until a sell has been seen.
  a_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_sell |-> out_min_sell == 8'd0)
    else $error("min sell set without sell");

endmodule

bind per_stock_order_statistics_unit psos_checker u_psos_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_min_sell    (out_min_sell),
  .out_has_sell    (out_has_sell),
  .out_has_buy     (out_has_buy),
  .out_value_sum   (out_value_sum),
  .out_order_count (out_order_count),
  .out_dropped     (out_dropped)
);

`default_nettype wire
